FILE: rtl/dvr_pkg.sv
// Shared types and constants for the distance-vector route table.
// No dependencies; imported by distance_vector_route_table_unit.
package dvr_pkg;

  localparam int NodeCountDef = 256;
  localparam logic [15:0] Unreach = 16'd32767;
  localparam logic [15:0] TimeoutRst = 16'd2000;

  typedef enum logic [1:0] {
    FUNC_HEARTBEAT = 2'd0,
    FUNC_VECTOR    = 2'd1,
    FUNC_SWEEP     = 2'd2,
    FUNC_LOOKUP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_LOCAL   = 2'd1,
    STAT_FORWARD = 2'd2,
    STAT_UNREACH = 2'd3
  } status_e;

  typedef enum logic {
    CFG_OWN_ID  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_PASS1,
    ST_PASS2,
    ST_HOLD
  } state_e;

  // One table entry: route, neighbour flag and last heard time.
  typedef struct packed {
    logic        valid;
    logic [7:0]  hop;
    logic [15:0] cost;
    logic [15:0] metric;
    logic        nbr;
    logic [31:0] heard;
  } entry_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  next_hop;
    logic [15:0] route_cost;
    logic [15:0] distance;
    logic        advertise;
  } result_t;

endpackage

FILE: rtl/distance_vector_route_table_unit.sv
// Distance-vector route table: one synchronous table memory, its sequencer
// and the output register. Depends on dvr_pkg.

// After reset the table is cleared one entry a cycle, during which no
// request is taken (register writes are). A heartbeat, vector entry or
// lookup reads a single table entry; a heartbeat or vector entry may write
// it back. A sweep makes two passes over the table through the single
// memory read port: the first pass marks silent neighbours dead and drops
// their routes, the second drops every route whose next hop died. A
// register write that moves the own node drops the route of the old own
// node in the same cycle, unless the sequencer writes or clears the table;
// the route stored for the current own node is never used. One result is
// given per request; a new request is taken while the previous result
// still waits at the output register.
module distance_vector_route_table_unit
  import dvr_pkg::*;
#(
  parameter int NODE_COUNT = NodeCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // node[7:0], target[15:8], advertised[31:16], link_cost[46:32],
  // now_ms[78:47], zero padding
  input  logic [79:0] s_axis_tdata,
  // func[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_hop[7:0], route_cost[23:8], distance[39:24], advertise[40],
  // zero padding
  output logic [47:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]  m_axis_tuser
);

  localparam int IW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW = $clog2(NODE_COUNT + 1);

  state_e state_q, state_d;
  logic [7:0]  own_q;
  logic [15:0] timeout_q;
  logic [CW-1:0] ctr_q, ctr_d;
  logic [IW-1:0] pa_q, pa_d;
  logic pv_q, pv_d;
  logic any_q, any_d;
  logic [NODE_COUNT-1:0] dead_q, dead_d;

  // Latched request fields
  func_e       func_q;
  logic [7:0]  node_q, target_q;
  logic [15:0] adv_q;
  logic [14:0] link_q;
  logic [31:0] now_q;

  result_t res_q, res_hold_d, res_c;
  logic    res_load, hold_load;
  logic    mv_q;
  result_t out_q;

  entry_t mem_q [NODE_COUNT];
  entry_t rd_q;
  logic [IW-1:0] raddr, waddr;
  logic   we, drop_we;
  entry_t wdata;

  entry_t drop_e;
  logic   accept, slot_free;
  logic [31:0] node_x, target_x, in_node_x, in_target_x, hop_x, pa_x, own_x;
  logic node_ok, target_ok, own_ok;
  logic [16:0] sum;
  logic [31:0] elapsed;
  logic fsm_we;
  entry_t fsm_wdata;
  logic [IW-1:0] fsm_waddr;

  assign drop_e = '{valid: 1'b0, hop: '0, cost: '0, metric: Unreach, nbr: 1'b0,
                    heard: '0};
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign slot_free = !mv_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  assign node_x      = {24'd0, node_q};
  assign target_x    = {24'd0, target_q};
  assign in_node_x   = {24'd0, s_axis_tdata[7:0]};
  assign in_target_x = {24'd0, s_axis_tdata[15:8]};
  assign hop_x       = {24'd0, rd_q.hop};
  assign pa_x        = 32'(pa_q);
  assign own_x       = {24'd0, own_q};
  assign node_ok     = node_x < 32'(NODE_COUNT);
  assign target_ok   = target_x < 32'(NODE_COUNT);
  assign own_ok      = own_x < 32'(NODE_COUNT);
  assign sum         = {2'd0, link_q} + {1'b0, adv_q};
  assign elapsed     = now_q - rd_q.heard;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q     <= '0;
      timeout_q <= TimeoutRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_OWN_ID) begin
        own_q <= cfg_data_i[7:0];
      end else begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // Request field capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_e'(s_axis_tuser);
      node_q   <= s_axis_tdata[7:0];
      target_q <= s_axis_tdata[15:8];
      adv_q    <= s_axis_tdata[31:16];
      link_q   <= s_axis_tdata[46:32];
      now_q    <= s_axis_tdata[78:47];
    end
  end

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ctr_q   <= '0;
      pa_q    <= '0;
      pv_q    <= 1'b0;
      any_q   <= 1'b0;
      dead_q  <= '0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      pa_q    <= pa_d;
      pv_q    <= pv_d;
      any_q   <= any_d;
      dead_q  <= dead_d;
    end
  end

  // Next state, memory access and result
  always_comb begin
    state_d    = state_q;
    ctr_d      = ctr_q;
    pa_d       = pa_q;
    pv_d       = 1'b0;
    any_d      = any_q;
    dead_d     = dead_q;
    raddr      = '0;
    fsm_we     = 1'b0;
    fsm_waddr  = '0;
    fsm_wdata  = rd_q;
    res_c      = '{status: STAT_DONE, next_hop: '0, route_cost: '0, distance: '0,
                   advertise: 1'b0};
    res_hold_d = res_q;
    res_load   = 1'b0;
    hold_load  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        fsm_we    = 1'b1;
        fsm_waddr = ctr_q[IW-1:0];
        fsm_wdata = drop_e;
        ctr_d     = ctr_q + 1'b1;
        if (ctr_q == CW'(NODE_COUNT - 1)) begin
          state_d = ST_IDLE;
          ctr_d   = '0;
        end
      end
      ST_IDLE: begin
        raddr = (func_e'(s_axis_tuser) == FUNC_VECTOR) ? in_target_x[IW-1:0]
                                                       : in_node_x[IW-1:0];
        if (accept) begin
          if (func_e'(s_axis_tuser) == FUNC_SWEEP) begin
            state_d = ST_PASS1;
            ctr_d   = '0;
            any_d   = 1'b0;
            dead_d  = '0;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        case (func_q)
          FUNC_HEARTBEAT: begin
            fsm_waddr = node_x[IW-1:0];
            fsm_we    = node_ok;
            fsm_wdata.heard = now_q;
            if (node_q != own_q) begin
              fsm_wdata.metric = {1'b0, link_q};
              fsm_wdata.cost   = {1'b0, link_q};
              fsm_wdata.hop    = node_q;
              fsm_wdata.valid  = 1'b1;
              fsm_wdata.nbr    = 1'b1;
            end
          end
          FUNC_VECTOR: begin
            fsm_waddr = target_x[IW-1:0];
            if (node_ok && target_ok && node_q != own_q && target_q != own_q) begin
              if (adv_q < Unreach) begin
                if (sum < {1'b0, Unreach}) begin
                  if ({1'b0, rd_q.metric} > sum) begin
                    fsm_we           = 1'b1;
                    fsm_wdata.metric = sum[15:0];
                    fsm_wdata.cost   = sum[15:0];
                    fsm_wdata.hop    = node_q;
                    fsm_wdata.valid  = 1'b1;
                  end else if ({1'b0, rd_q.metric} == sum && rd_q.valid &&
                               rd_q.hop > node_q) begin
                    fsm_we        = 1'b1;
                    fsm_wdata.hop = node_q;
                  end
                end
              end else if (rd_q.valid && rd_q.hop == node_q) begin
                fsm_we           = 1'b1;
                fsm_wdata.metric = Unreach;
                fsm_wdata.cost   = '0;
                fsm_wdata.hop    = '0;
                fsm_wdata.valid  = 1'b0;
                res_c.advertise  = 1'b1;
              end
            end
          end
          default: begin
            // Route lookup
            if (node_q == own_q) begin
              res_c.status = STAT_LOCAL;
            end else if (!node_ok) begin
              res_c.status   = STAT_UNREACH;
              res_c.distance = Unreach;
            end else if (rd_q.valid) begin
              res_c.status     = STAT_FORWARD;
              res_c.next_hop   = rd_q.hop;
              res_c.route_cost = rd_q.cost;
              res_c.distance   = rd_q.metric;
            end else begin
              res_c.status   = STAT_UNREACH;
              res_c.distance = rd_q.metric;
            end
          end
        endcase
        if (slot_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end else begin
          hold_load  = 1'b1;
          res_hold_d = res_c;
          state_d    = ST_HOLD;
        end
      end
      ST_PASS1, ST_PASS2: begin
        // Read one entry a cycle; the entry read last cycle is written back if it changes.
        if (ctr_q < CW'(NODE_COUNT)) begin
          raddr = ctr_q[IW-1:0];
          pa_d  = ctr_q[IW-1:0];
          pv_d  = 1'b1;
          ctr_d = ctr_q + 1'b1;
        end
        fsm_waddr = pa_q;
        fsm_wdata = rd_q;
        fsm_wdata.metric = Unreach;
        fsm_wdata.cost   = '0;
        fsm_wdata.hop    = '0;
        fsm_wdata.valid  = 1'b0;
        if (state_q == ST_PASS1) begin
          if (pv_q && pa_x != {24'd0, own_q} && rd_q.nbr && !elapsed[31] &&
              elapsed >= {16'd0, timeout_q}) begin
            fsm_we        = 1'b1;
            fsm_wdata.nbr = 1'b0;
            dead_d[pa_q]  = 1'b1;
            any_d         = 1'b1;
          end
          if (ctr_q == CW'(NODE_COUNT) && !pv_q) begin
            state_d = ST_PASS2;
            ctr_d   = '0;
          end
        end else begin
          fsm_we = pv_q && rd_q.valid && dead_q[hop_x[IW-1:0]];
          res_c.advertise = any_q;
          if (ctr_q == CW'(NODE_COUNT) && !pv_q) begin
            if (slot_free) begin
              res_load = 1'b1;
              state_d  = ST_IDLE;
            end else begin
              hold_load  = 1'b1;
              res_hold_d = res_c;
              state_d    = ST_HOLD;
            end
          end
        end
      end
      ST_HOLD: begin
        res_c = res_q;
        if (slot_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Write port: sequencer first, else a register write that moves the own
  // node drops the route of the old own node.
  always_comb begin
    drop_we = 1'b0;
    waddr   = fsm_waddr;
    wdata   = fsm_wdata;
    if (!fsm_we && state_q != ST_CLEAR && cfg_we_i && cfg_idx_i == CFG_OWN_ID &&
        own_ok) begin
      drop_we = 1'b1;
      waddr   = own_x[IW-1:0];
    end
    we = fsm_we || drop_we;
  end

  // Table memory. The own-node drop writes the route fields only and keeps
  // the neighbour fields.
  always_ff @(posedge clk_i) begin
    if (fsm_we) begin
      mem_q[waddr] <= wdata;
    end else if (drop_we) begin
      mem_q[waddr].valid  <= 1'b0;
      mem_q[waddr].hop    <= '0;
      mem_q[waddr].cost   <= '0;
      mem_q[waddr].metric <= Unreach;
    end
    rd_q <= mem_q[raddr];
  end

  // Held result while the output register is busy, and the output result
  always_ff @(posedge clk_i) begin
    if (hold_load) begin
      res_q <= res_hold_d;
    end
    if (res_load) begin
      out_q <= res_c;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else if (res_load) begin
      mv_q <= 1'b1;
    end else if (m_axis_tready) begin
      mv_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {7'd0, out_q.advertise, out_q.distance, out_q.route_cost,
                          out_q.next_hop};

  // No request is taken while the table is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready)
    else $error("request taken during table clear");

  // A local delivery always reports distance zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mv_q && out_q.status == STAT_LOCAL) |-> out_q.distance == 16'd0)
    else $error("local result with non-zero distance");

  // While idle the table is written only by a write to the own-node register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && state_q == ST_IDLE) |-> (cfg_we_i && !fsm_we && drop_we))
    else $error("table written while idle without a register write");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for distance_vector_route_table_unit: a queue-fed
// driver, a ready-throttling receiver and a monitor with its own route table.
// Depends on dvr_pkg and the unit under test.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dvr_pkg::*;

  localparam int NODES = 256;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES = 5;
  localparam int RAND_PER_PHASE = 385;

  typedef struct {
    func_e       func;
    logic [7:0]  node;
    logic [7:0]  target;
    logic [15:0] adv;
    logic [14:0] link;
    logic [31:0] now;
  } route_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  distance_vector_route_table_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // Shadow route table kept in step with the unit.
  logic [15:0] sh_dist [NODES];
  logic [7:0]  sh_hop [NODES];
  logic        sh_valid [NODES];
  logic [15:0] sh_cost [NODES];
  logic        sh_nbr [NODES];
  logic [31:0] sh_heard [NODES];
  logic [7:0]  sh_own;
  logic [15:0] sh_timeout;

  route_req_t pending_reqs[$];
  result_t    expected_results[$];
  int         errors = 0;
  int         reqs_queued = 0;
  int         reqs_sent = 0;
  int         results_seen = 0;
  int         sweeps_sent = 0;
  int         cycles = 0;
  bit         in_fire = 1'b0;
  bit         no_idle = 1'b0;
  bit         rx_hold = 1'b0;
  int         tx_gap = 0;
  int         rx_gap = 0;
  logic [31:0] clock_ms;

  function automatic void drop_entry(input int k);
    sh_dist[k] = Unreach;
    sh_valid[k] = 1'b0;
    sh_hop[k] = '0;
    sh_cost[k] = '0;
  endfunction

  task automatic shadow_reset();
    for (int k = 0; k < NODES; k++) begin
      drop_entry(k);
      sh_nbr[k] = 1'b0;
      sh_heard[k] = '0;
    end
    sh_own = '0;
    sh_timeout = TimeoutRst;
    sh_dist[0] = '0;
  endtask

  // Apply one request to the shadow table and return the answer it gives.
  function automatic result_t route_answer(input route_req_t r);
    result_t     res;
    logic [16:0] sum;
    logic [31:0] elapsed;
    res = '{status: STAT_DONE, next_hop: '0, route_cost: '0, distance: '0,
            advertise: 1'b0};
    case (r.func)
      FUNC_HEARTBEAT: begin
        if (r.node != sh_own) begin
          sh_dist[r.node] = {1'b0, r.link};
          sh_cost[r.node] = {1'b0, r.link};
          sh_nbr[r.node] = 1'b1;
          sh_hop[r.node] = r.node;
          sh_valid[r.node] = 1'b1;
        end
        sh_heard[r.node] = r.now;
      end
      FUNC_VECTOR: begin
        if (r.node != sh_own && r.target != sh_own) begin
          if (r.adv < Unreach) begin
            sum = r.link + r.adv;
            if (sum < Unreach) begin
              if (sh_dist[r.target] > sum) begin
                sh_dist[r.target] = sum[15:0];
                sh_cost[r.target] = sum[15:0];
                sh_hop[r.target] = r.node;
                sh_valid[r.target] = 1'b1;
              end else if (sh_dist[r.target] == sum && sh_valid[r.target] &&
                           sh_hop[r.target] > r.node) begin
                sh_hop[r.target] = r.node;
              end
            end
          end else if (sh_valid[r.target] && sh_hop[r.target] == r.node) begin
            drop_entry(r.target);
            res.advertise = 1'b1;
          end
        end
      end
      FUNC_SWEEP: begin
        for (int i = 0; i < NODES; i++) begin
          if (i == sh_own || !sh_nbr[i]) continue;
          elapsed = r.now - sh_heard[i];
          if (elapsed[31] || elapsed < sh_timeout) continue;
          sh_nbr[i] = 1'b0;
          drop_entry(i);
          res.advertise = 1'b1;
          for (int j = 0; j < NODES; j++) begin
            if (j == sh_own || j == i) continue;
            if (sh_valid[j] && sh_hop[j] == i) drop_entry(j);
          end
        end
      end
      default: begin
        res.distance = sh_dist[r.node];
        if (r.node == sh_own) begin
          res.status = STAT_LOCAL;
        end else if (sh_valid[r.node]) begin
          res.status = STAT_FORWARD;
          res.next_hop = sh_hop[r.node];
          res.route_cost = sh_cost[r.node];
        end else begin
          res.status = STAT_UNREACH;
        end
      end
    endcase
    return res;
  endfunction

  // Register write, applied to the shadow copy at the same time.
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    if (idx == CFG_OWN_ID) begin
      drop_entry(sh_own);
      sh_own = value[7:0];
      drop_entry(sh_own);
      sh_dist[sh_own] = '0;
    end else begin
      sh_timeout = value;
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_node();
    int r;
    r = $urandom_range(0, 9);
    if (r < 1) return sh_own;
    if (r < 8) return 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  task automatic push_req(input func_e f, input logic [7:0] n, input logic [7:0] t,
                          input logic [15:0] a, input logic [14:0] l,
                          input logic [31:0] nw);
    route_req_t r;
    r = '{func: f, node: n, target: t, adv: a, link: l, now: nw};
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  // Random traffic, mostly well-formed neighbour chatter on a few nodes.
  task automatic push_random_req();
    int          kind;
    int          r;
    logic [15:0] a;
    logic [14:0] l;
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    if (r < 70) a = 16'($urandom_range(0, 200));
    else if (r < 85)
      a = ($urandom_range(0, 1) != 0) ? Unreach : 16'($urandom_range(32767, 65535));
    else a = 16'($urandom);
    l = ($urandom_range(0, 9) < 8) ? 15'($urandom_range(1, 100)) : 15'($urandom);
    r = $urandom_range(0, 99);
    if (r < 3) clock_ms = clock_ms - 32'($urandom_range(1, 5000));
    else if (r < 5) clock_ms = $urandom;
    else clock_ms = clock_ms + 32'($urandom_range(0, 600));
    if (kind < 20) push_req(FUNC_HEARTBEAT, pick_node(), 8'($urandom), a, l, clock_ms);
    else if (kind < 64) push_req(FUNC_VECTOR, pick_node(), pick_node(), a, l, clock_ms);
    else if (kind < 67) push_req(FUNC_SWEEP, 8'($urandom), 8'($urandom), a, l, clock_ms);
    else push_req(FUNC_LOOKUP, pick_node(), 8'($urandom), a, l, clock_ms);
  endtask

  // Every queued request has given its result.
  task automatic wait_idle();
    wait (results_seen >= reqs_queued);
    repeat (20) @(posedge clk_i);
  endtask

  // Request driver: one request at a time, with random gaps between them.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        route_req_t r;
        r = pending_reqs.pop_front();
        s_axis_tdata <= {1'b0, r.now, r.link, r.adv, r.target, r.node};
        s_axis_tuser <= r.func;
        s_axis_tvalid <= 1'b1;
        tx_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure, plus one long hold-off.
  always @(negedge clk_i) begin
    if (rx_hold) begin
      m_axis_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      rx_gap <= pick_gap();
    end
  end

  // Monitor: check every result, then predict for every accepted request.
  always @(posedge clk_i) begin
    cycles++;
    in_fire = rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_t got;
      result_t want;
      got = '{status: status_e'(m_axis_tuser), next_hop: m_axis_tdata[7:0],
              route_cost: m_axis_tdata[23:8], distance: m_axis_tdata[39:24],
              advertise: m_axis_tdata[40]};
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status || got.next_hop != want.next_hop ||
            got.route_cost != want.route_cost || got.distance != want.distance ||
            got.advertise != want.advertise || m_axis_tdata[47:41] != '0) begin
          errors++;
          if (errors <= 10)
            $display("mismatch on result %0d: expected %p, got %p", results_seen, want, got);
        end
      end
    end
    if (in_fire) begin
      route_req_t r;
      r.func = func_e'(s_axis_tuser);
      r.node = s_axis_tdata[7:0];
      r.target = s_axis_tdata[15:8];
      r.adv = s_axis_tdata[31:16];
      r.link = s_axis_tdata[46:32];
      r.now = s_axis_tdata[78:47];
      reqs_sent++;
      if (r.func == FUNC_SWEEP) sweeps_sent++;
      expected_results.push_back(route_answer(r));
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering requests.
  initial begin
    wait (reqs_sent > 600);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    logic [15:0] own_ids [PHASES];
    logic [15:0] timeouts [PHASES];
    own_ids = '{16'd0, 16'd255, 16'd3, 16'($urandom_range(0, 255)), 16'd0};
    timeouts = '{16'd2000, 16'd65535, 16'd1, 16'($urandom_range(200, 3000)), 16'd500};
    shadow_reset();
    clock_ms = $urandom;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: own node 0, default timeout.
    push_req(FUNC_LOOKUP, 8'd0, 8'd0, 16'd0, 15'd0, 32'd0);
    push_req(FUNC_LOOKUP, 8'd9, 8'd0, 16'd0, 15'd0, 32'd0);
    push_req(FUNC_HEARTBEAT, 8'd1, 8'd0, 16'd0, 15'd10, 32'd100);
    push_req(FUNC_HEARTBEAT, 8'd2, 8'd0, 16'd0, 15'd10, 32'd100);
    push_req(FUNC_HEARTBEAT, 8'd255, 8'hFF, 16'hFFFF, 15'h7FFF, 32'hFFFF_FFFF);
    push_req(FUNC_HEARTBEAT, 8'd0, 8'd0, 16'd0, 15'd5, 32'd100);
    push_req(FUNC_VECTOR, 8'd2, 8'd7, 16'd20, 15'd10, 32'd0);
    push_req(FUNC_VECTOR, 8'd1, 8'd7, 16'd20, 15'd10, 32'd0);
    push_req(FUNC_VECTOR, 8'd1, 8'd7, 16'd50, 15'd10, 32'd0);
    push_req(FUNC_LOOKUP, 8'd7, 8'd0, 16'd0, 15'd0, 32'd0);
    push_req(FUNC_VECTOR, 8'd2, 8'd7, 16'd65535, 15'd10, 32'd0);
    push_req(FUNC_VECTOR, 8'd1, 8'd7, 16'd32767, 15'd10, 32'd0);
    push_req(FUNC_VECTOR, 8'd1, 8'd8, 16'd32766, 15'd5, 32'd0);
    push_req(FUNC_VECTOR, 8'd0, 8'd8, 16'd1, 15'd1, 32'd0);
    push_req(FUNC_VECTOR, 8'd1, 8'd0, 16'd1, 15'd1, 32'd0);
    push_req(FUNC_VECTOR, 8'd2, 8'd9, 16'd3, 15'd4, 32'd0);
    push_req(FUNC_HEARTBEAT, 8'd2, 8'd0, 16'd0, 15'd40, 32'd150);
    push_req(FUNC_SWEEP, 8'd0, 8'd0, 16'd0, 15'd0, 32'd50);
    push_req(FUNC_SWEEP, 8'd0, 8'd0, 16'd0, 15'd0, 32'd2100);
    push_req(FUNC_LOOKUP, 8'd9, 8'd0, 16'd0, 15'd0, 32'd0);
    push_req(FUNC_LOOKUP, 8'd255, 8'd0, 16'd0, 15'd0, 32'd0);
    push_req(FUNC_SWEEP, 8'hFF, 8'hFF, 16'hFFFF, 15'h7FFF, 32'h0000_1000);
    push_req(FUNC_LOOKUP, 8'd1, 8'd0, 16'd0, 15'd0, 32'd0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_reg(CFG_OWN_ID, own_ids[p]);
      write_reg(CFG_TIMEOUT, timeouts[p]);
      no_idle = (p == 2);
      for (int n = 0; n < RAND_PER_PHASE; n++) push_random_req();
      wait_idle();
    end

    $display("%0d requests (%0d sweeps) and %0d results over %0d register settings,",
             reqs_sent, sweeps_sent, results_seen, PHASES + 1);
    $display("including a long receiver stall; %0d mismatches", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/dvr_pkg.sv
rtl/distance_vector_route_table_unit.sv
dv/testbench.sv
